// File: rtl/vfdg_pkg.sv
// Shared types and constants of the volume forward-difference gradient block.
// Holds field widths, configuration register indexes and the result record.
// No dependencies.
package vfdg_pkg;

    localparam int IDX_W   = 24;  // linear voxel index
    localparam int DIFF_W  = 25;  // scaled difference
    localparam int DIM_W   = 9;   // extent and position registers
    localparam int SCALE_W = 24;  // Q8.16 reciprocal of the norm
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int RES_FIFO_DEPTH = 8;
    localparam int RES_FIFO_AW    = 3;
    localparam int RES_FIFO_CW    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_X   = 3'd0,
        CFG_DIM_Y   = 3'd1,
        CFG_DIM_Z   = 3'd2,
        CFG_AXIS    = 3'd3,
        CFG_ADJOINT = 3'd4,
        CFG_SCALE   = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef struct packed {
        logic [IDX_W-1:0]         voxel_index;
        logic signed [DIFF_W-1:0] diff_value;
        logic                     last_result;
    } t_result;

    // Up to two results written into the result queue in one cycle, first slot first.
    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    b_valid;
        t_result b;
    } t_push_pair;

endpackage

// File: rtl/vfdg_store.sv
// Sample delay store: one synchronous write port and one registered read port.
// Read returns the old contents on a same-address write. Depends on nothing.
module vfdg_store #(
    parameter int DEPTH       = 65536,
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = 16
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [SAMPLE_BITS-1:0] i_wr_data,
    input  logic                   i_re,
    input  logic [AW-1:0]          i_rd_addr,
    output logic [SAMPLE_BITS-1:0] o_rd_data
);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= mem[i_rd_addr];
        end
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/vfdg_result_fifo.sv
// Result queue: takes up to two results a cycle, hands out one a cycle on i_pop.
// Depends on vfdg_pkg for the result record and queue sizes.
module vfdg_result_fifo
    import vfdg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_push_pair             i_push,
    input  logic                   i_pop,
    output t_result                o_head,
    output logic                   o_not_empty,
    output logic [RES_FIFO_CW-1:0] o_count
);

    t_result                r_mem [RES_FIFO_DEPTH];
    logic [RES_FIFO_AW-1:0] r_wr_ptr;
    logic [RES_FIFO_AW-1:0] r_rd_ptr;
    logic [RES_FIFO_CW-1:0] r_count;
    logic [RES_FIFO_AW-1:0] b_addr;
    logic [RES_FIFO_CW-1:0] n_count;

    assign b_addr  = r_wr_ptr + RES_FIFO_AW'(i_push.a_valid);
    assign n_count = r_count + RES_FIFO_CW'(i_push.a_valid) + RES_FIFO_CW'(i_push.b_valid)
                     - RES_FIFO_CW'(i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr_ptr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_mem[b_addr] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RES_FIFO_AW'(i_push.a_valid) + RES_FIFO_AW'(i_push.b_valid);
            r_rd_ptr <= r_rd_ptr + RES_FIFO_AW'(i_pop);
            r_count  <= n_count;
        end
    end

    assign o_head      = r_mem[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_count     = r_count;

endmodule

// File: rtl/volume_forward_difference_gradient_top.sv
// Streaming 3-D forward-difference gradient and its adjoint (negative divergence).
// Voxels arrive in raster order (x fastest) at one request per clock while o_stall
// is low. Each accepted voxel costs one read and one write of the sample delay
// store (a single-port-pair synchronous RAM of MAX_DIM_X * MAX_DIM_Y entries), which
// sets the rate at one voxel per cycle. A result passes the stage B and stage C
// registers and the result queue before it leaves. Forward mode gives the difference
// for the voxel one stride back and, on the last slice, a zero for the current voxel
// as well; adjoint mode gives one result for the current voxel. Results leave one
// per cycle while i_stall is low through an eight-entry queue, so a stream in which
// every voxel yields two results (forward mode on the last slice of an axis longer
// than one, such as the last plane along z) is held to the output's pace by o_stall.
// The store is not cleared at reset; reading a never-written entry gives undefined
// difference values. Write configuration only while no requests are in flight.
module volume_forward_difference_gradient_top
    import vfdg_pkg::*;
#(
    parameter int MAX_DIM_X   = 256,
    parameter int MAX_DIM_Y   = 256,
    parameter int MAX_DIM_Z   = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    // voxel input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    // result output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [IDX_W-1:0]              o_voxel_index,
    output logic signed [DIFF_W-1:0]      o_diff_value,
    output logic                          o_last_result
);

    localparam int DEPTH = MAX_DIM_X * MAX_DIM_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = AW + 1;            // holds a stride up to DEPTH
    localparam int DW    = SAMPLE_BITS + 1;   // raw difference
    localparam int PW    = DW + SCALE_W + 1;  // scaled product
    localparam int QW    = (PW - 16 > DIFF_W) ? PW - 16 : DIFF_W + 1;
    localparam logic signed [QW-1:0] SAT_HI = QW'(16777215);
    localparam logic signed [QW-1:0] SAT_LO = QW'(-16777216);
    localparam logic [IDX_W-1:0] IDX_LAST = '1;

    // Extents of 0 act as 1, extents beyond the maximum act as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int mx);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (int'(v) > mx) begin
            return DIM_W'(mx);
        end
        return v;
    endfunction

    function automatic logic [SW-1:0] plane_size(input logic [DIM_W-1:0] a,
                                                 input logic [DIM_W-1:0] b);
        logic [2*DIM_W-1:0] p;
        p = {{DIM_W{1'b0}}, a} * {{DIM_W{1'b0}}, b};
        return SW'(p);
    endfunction

    // ---------------------------------------------------------------- configuration
    logic [DIM_W-1:0]   r_dx, r_dy, r_dz;
    logic [SW-1:0]      r_plane;           // dx * dy, the z stride
    logic [1:0]         r_axis;
    logic               r_adj;
    logic [SCALE_W-1:0] r_scale;
    logic [DIM_W-1:0]   cfg_dim;

    assign o_cfg_ready = 1'b1;
    assign cfg_dim     = i_cfg_data[DIM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx    <= clamp_dim(DIM_W'(256), MAX_DIM_X);
            r_dy    <= clamp_dim(DIM_W'(256), MAX_DIM_Y);
            r_dz    <= clamp_dim(DIM_W'(256), MAX_DIM_Z);
            r_plane <= plane_size(clamp_dim(DIM_W'(256), MAX_DIM_X),
                                  clamp_dim(DIM_W'(256), MAX_DIM_Y));
            r_axis  <= AXIS_X;
            r_adj   <= 1'b0;
            r_scale <= SCALE_W'(65536);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_DIM_X: begin
                    r_dx    <= clamp_dim(cfg_dim, MAX_DIM_X);
                    r_plane <= plane_size(clamp_dim(cfg_dim, MAX_DIM_X), r_dy);
                end
                CFG_DIM_Y: begin
                    r_dy    <= clamp_dim(cfg_dim, MAX_DIM_Y);
                    r_plane <= plane_size(r_dx, clamp_dim(cfg_dim, MAX_DIM_Y));
                end
                CFG_DIM_Z:   r_dz    <= clamp_dim(cfg_dim, MAX_DIM_Z);
                CFG_AXIS:    r_axis  <= i_cfg_data[1:0];
                CFG_ADJOINT: r_adj   <= i_cfg_data[0];
                CFG_SCALE:   r_scale <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- stage A: accept
    logic [DIM_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [IDX_W-1:0] r_counter;
    logic [AW-1:0]    r_wr_addr;             // r_counter modulo DEPTH
    logic             accept;
    logic [DIM_W-1:0] sel_pos, sel_len;
    logic [SW-1:0]    sel_stride;
    logic [AW-1:0]    rd_addr;
    logic             a_first, a_last, a_len1;
    logic             wrap_x, wrap_y, wrap_z, counter_wrap;

    assign accept = i_valid && !o_stall;

    always_comb begin
        case (r_axis)
            AXIS_Y: begin
                sel_pos    = r_pos_y;
                sel_len    = r_dy;
                sel_stride = SW'(r_dx);
            end
            AXIS_Z: begin
                sel_pos    = r_pos_z;
                sel_len    = r_dz;
                sel_stride = r_plane;
            end
            default: begin
                sel_pos    = r_pos_x;
                sel_len    = r_dx;
                sel_stride = SW'(1);
            end
        endcase
    end

    assign a_first = (sel_pos == '0);
    assign a_last  = (sel_pos >= sel_len - DIM_W'(1));
    assign a_len1  = (sel_len == DIM_W'(1));

    // Step one stride back in the circular store.
    always_comb begin
        if (SW'(r_wr_addr) >= sel_stride) begin
            rd_addr = AW'(SW'(r_wr_addr) - sel_stride);
        end else begin
            rd_addr = AW'(SW'(r_wr_addr) + SW'(DEPTH) - sel_stride);
        end
    end

    assign wrap_x       = (r_pos_x >= r_dx - DIM_W'(1));
    assign wrap_y       = (r_pos_y >= r_dy - DIM_W'(1));
    assign wrap_z       = (r_pos_z >= r_dz - DIM_W'(1));
    assign counter_wrap = (r_counter == IDX_LAST);

    // Advance the raster position; the end of the volume restarts at index zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_pos_z   <= '0;
            r_counter <= '0;
            r_wr_addr <= '0;
        end else if (accept) begin
            if (wrap_x && wrap_y && wrap_z) begin
                r_counter <= '0;
                r_wr_addr <= '0;
            end else begin
                r_counter <= r_counter + IDX_W'(1);
                if (counter_wrap || r_wr_addr == AW'(DEPTH - 1)) begin
                    r_wr_addr <= '0;
                end else begin
                    r_wr_addr <= r_wr_addr + AW'(1);
                end
            end
            if (wrap_x) begin
                r_pos_x <= '0;
                if (wrap_y) begin
                    r_pos_y <= '0;
                    if (wrap_z) begin
                        r_pos_z <= '0;
                    end else begin
                        r_pos_z <= r_pos_z + DIM_W'(1);
                    end
                end else begin
                    r_pos_y <= r_pos_y + DIM_W'(1);
                end
            end else begin
                r_pos_x <= r_pos_x + DIM_W'(1);
            end
        end
    end

    logic [SAMPLE_BITS-1:0] store_rd;

    vfdg_store #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (i_sample_value),
        .i_re      (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (store_rd)
    );

    // ---------------------------------------------------------------- stage B: difference
    logic                          r_b_valid;
    logic signed [SAMPLE_BITS-1:0] r_b_cur;
    logic                          r_b_first, r_b_last, r_b_len1;
    logic [IDX_W-1:0]              r_b_here, r_b_back;
    logic signed [DW-1:0]          cur_e, prev_e, b_diff;
    logic signed [PW-1:0]          b_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_cur   <= i_sample_value;
            r_b_first <= a_first;
            r_b_last  <= a_last;
            r_b_len1  <= a_len1;
            r_b_here  <= r_counter;
            r_b_back  <= r_counter - IDX_W'(sel_stride);
        end
    end

    assign cur_e  = {r_b_cur[SAMPLE_BITS-1], r_b_cur};
    assign prev_e = {store_rd[SAMPLE_BITS-1], store_rd};

    always_comb begin
        if (r_adj) begin
            if (r_b_len1) begin
                b_diff = '0;
            end else if (r_b_first) begin
                b_diff = -cur_e;
            end else if (r_b_last) begin
                b_diff = prev_e;
            end else begin
                b_diff = prev_e - cur_e;
            end
        end else begin
            b_diff = cur_e - prev_e;
        end
    end

    assign b_prod = PW'(b_diff) * PW'($signed({1'b0, r_scale}));

    // ---------------------------------------------------------------- stage C: scale out
    logic                 r_c_emit1, r_c_emit2, r_c_last1;
    logic [IDX_W-1:0]     r_c_idx1, r_c_here;
    logic signed [PW-1:0] r_c_prod;
    logic signed [PW-1:0] c_shift;
    logic signed [QW-1:0] c_q;
    logic signed [DIFF_W-1:0] c_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_emit1 <= 1'b0;
            r_c_emit2 <= 1'b0;
        end else begin
            r_c_emit1 <= r_b_valid && (r_adj || !r_b_first);
            r_c_emit2 <= r_b_valid && !r_adj && r_b_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_c_prod  <= b_prod;
            r_c_idx1  <= r_adj ? r_b_here : r_b_back;
            r_c_last1 <= r_adj || !r_b_last;
            r_c_here  <= r_b_here;
        end
    end

    // Arithmetic shift floors; then clip to the 25-bit range.
    assign c_shift = r_c_prod >>> 16;
    assign c_q     = QW'(c_shift);

    always_comb begin
        if (c_q > SAT_HI) begin
            c_val = SAT_HI[DIFF_W-1:0];
        end else if (c_q < SAT_LO) begin
            c_val = SAT_LO[DIFF_W-1:0];
        end else begin
            c_val = c_q[DIFF_W-1:0];
        end
    end

    t_push_pair push;

    always_comb begin
        push.a_valid           = r_c_emit1;
        push.a.voxel_index     = r_c_idx1;
        push.a.diff_value      = c_val;
        push.a.last_result     = r_c_last1;
        push.b_valid           = r_c_emit2;
        push.b.voxel_index     = r_c_here;
        push.b.diff_value      = '0;
        push.b.last_result     = 1'b1;
    end

    // ---------------------------------------------------------------- result queue
    t_result                head;
    logic                   q_not_empty;
    logic [RES_FIFO_CW-1:0] q_count;
    logic                   pop;
    logic [RES_FIFO_CW+1:0] committed;

    assign pop = q_not_empty && !i_stall;

    vfdg_result_fifo u_results (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop       (pop),
        .o_head      (head),
        .o_not_empty (q_not_empty),
        .o_count     (q_count)
    );

    // Reserve two queue slots for every request in flight plus the next one;
    // the pipeline itself never holds.
    assign committed = (RES_FIFO_CW+2)'(q_count)
                     + (RES_FIFO_CW+2)'({r_b_valid, 1'b0})
                     + (RES_FIFO_CW+2)'({(r_c_emit1 || r_c_emit2), 1'b0})
                     + (RES_FIFO_CW+2)'(2);
    assign o_stall   = (committed > (RES_FIFO_CW+2)'(RES_FIFO_DEPTH));

    assign o_valid       = q_not_empty;
    assign o_voxel_index = head.voxel_index;
    assign o_diff_value  = head.diff_value;
    assign o_last_result = head.last_result;

endmodule
